// ===== src/lmstr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmstr_pkg: shared types and constants for the LMS weight trainer
// Field widths, multiplier widths, command codes and saturation helpers.
// ----------------------------------------------------------------------------
package lmstr_pkg;

	localparam int NUM_WEIGHTS = 3;

	localparam int X_W    = 16;
	localparam int W_W    = 24;
	localparam int RATE_W = 16;
	localparam int CMD_W  = 2;
	localparam int CFG_IDX_W = 2;

	// shared multiplier: A is a weight, an error or rate*error; B is an input or the rate
	localparam int MUL_A_W = W_W + RATE_W + 1;
	localparam int MUL_B_W = X_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int ACC_W = W_W + X_W + $clog2(NUM_WEIGHTS + 1);
	localparam int IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int CNT_W = $clog2(NUM_WEIGHTS + 1);

	localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
	localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_TRAIN   = 2'd0,
		CMD_PREDICT = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE  = 2'd0,
		REG_INIT0 = 2'd1,
		REG_INIT1 = 2'd2,
		REG_INIT2 = 2'd3
	} reg_idx_t;

	function automatic logic clip24(input logic signed [31:0] v);
		logic hi;
		logic lo;
		hi = (v > 32'(W_MAX));
		lo = (v < 32'(W_MIN));
		return hi | lo;
	endfunction

	function automatic logic signed [W_W-1:0] sat24(input logic signed [31:0] v);
		logic signed [W_W-1:0] r;
		if (v > 32'(W_MAX)) begin
			r = W_MAX;
		end else if (v < 32'(W_MIN)) begin
			r = W_MIN;
		end else begin
			r = v[W_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/lmstr_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmstr_mul: shared signed multiplier
// One signed product per enabled cycle, registered at the output.
// ----------------------------------------------------------------------------
module lmstr_mul
	import lmstr_pkg::*;
#(
	parameter int A_W = MUL_A_W,
	parameter int B_W = MUL_B_W
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [A_W-1:0]    a,
	input  wire logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0]     p
);

	logic signed [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

// ===== src/lms_three_weight_trainer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lms_three_weight_trainer_top: LMS delta-rule trainer for a linear neuron
// Three Q7.16 weights, train / predict / load commands on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  cfg     | cfg_we               | cfg_index, cfg_data
//  in      | in_valid, in_stall   | command, x_0, x_1, x_2, target
//  out     | out_valid, out_stall | value_0..2, sum_out, error_out, saturated
//
//  Train runs DOT, ERR, RATE, COPY, STEP and FIN from accept to result, predict
//  DOT, ERR and FIN, load FIN only; all products go through one multiplier.
//  Reset clears the weights, sets the rate to 655 and empties the output.
//  in_stall is high while an item is in work or a result waits for a full
//  output register; unused command 3 is dropped with no result.
// ----------------------------------------------------------------------------
module lms_three_weight_trainer_top
	import lmstr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [W_W-1:0]          cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [CMD_W-1:0]        command,
	input  wire logic signed [X_W-1:0]   x_0,
	input  wire logic signed [X_W-1:0]   x_1,
	input  wire logic signed [X_W-1:0]   x_2,
	input  wire logic signed [X_W-1:0]   target,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [W_W-1:0]        value_0,
	output logic signed [W_W-1:0]        value_1,
	output logic signed [W_W-1:0]        value_2,
	output logic signed [W_W-1:0]        sum_out,
	output logic signed [W_W-1:0]        error_out,
	output logic                         saturated
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DOT  = 7'b0000010,
		S_ERR  = 7'b0000100,
		S_RATE = 7'b0001000,
		S_COPY = 7'b0010000,
		S_STEP = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WEIGHTS);

	state_t                       state_q;
	logic [CNT_W-1:0]             cnt_q;
	cmd_t                         cmd_q;
	logic [RATE_W-1:0]            rate_q;
	logic signed [W_W-1:0]        init_q [NUM_WEIGHTS];
	logic signed [X_W-1:0]        x_q    [NUM_WEIGHTS];
	logic signed [W_W-1:0]        w_q    [NUM_WEIGHTS];
	logic signed [W_W-1:0]        pv_q   [NUM_WEIGHTS];
	logic signed [X_W-1:0]        tgt_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [W_W-1:0]        sum_q;
	logic signed [W_W-1:0]        err_q;
	logic signed [MUL_A_W-1:0]    re_q;
	logic                         flag_q;

	logic                         out_valid_q;
	logic signed [W_W-1:0]        value_q [NUM_WEIGHTS];
	logic signed [W_W-1:0]        sum_out_q;
	logic signed [W_W-1:0]        err_out_q;
	logic                         sat_out_q;

	logic                         accept;
	logic                         issue;
	logic                         mul_en;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;
	logic signed [MUL_P_W-1:0]    prod;
	logic signed [MUL_P_W-1:0]    prod_r12;
	logic signed [MUL_P_W-1:0]    prod_r28;
	logic signed [31:0]           pv_full;
	logic signed [31:0]           step_full;
	logic signed [31:0]           nw_full;
	logic signed [ACC_W-1:0]      acc_r;
	logic signed [31:0]           sum_full;
	logic signed [31:0]           err_full;
	logic                         out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign issue    = (cnt_q != CNT_LAST);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_DOT: begin
				mul_en = issue;
				mul_a  = MUL_A_W'(w_q[0]);
				mul_b  = MUL_B_W'(x_q[0]);
			end
			S_RATE: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(err_q);
				mul_b  = {1'b0, rate_q};
			end
			S_STEP: begin
				mul_en = issue;
				mul_a  = re_q;
				mul_b  = MUL_B_W'(x_q[0]);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	lmstr_mul #(
		.A_W(MUL_A_W),
		.B_W(MUL_B_W)
	) u_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	always_comb begin
		prod_r12  = prod + MUL_P_W'(2048);
		pv_full   = prod_r12[43:12];
		prod_r28  = prod + (MUL_P_W'(1) <<< 27);
		step_full = 32'($signed(prod_r28[MUL_P_W-1:28]));
		nw_full   = 32'(w_q[0]) + step_full;
		acc_r     = acc_q + ACC_W'(2048);
		sum_full  = 32'($signed(acc_r[ACC_W-1:12]));
		err_full  = (32'(tgt_q) <<< 4) - sum_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(655);
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				init_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RATE:  rate_q    <= cfg_data[RATE_W-1:0];
				REG_INIT0: init_q[0] <= cfg_data;
				REG_INIT1: init_q[1] <= cfg_data;
				REG_INIT2: init_q[2] <= cfg_data;
				default:   rate_q    <= rate_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			cmd_q   <= CMD_TRAIN;
			flag_q  <= 1'b0;
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= cmd_t'(command);
						cnt_q  <= '0;
						flag_q <= 1'b0;
						case (cmd_t'(command))
							CMD_TRAIN, CMD_PREDICT: begin
								state_q <= S_DOT;
							end
							CMD_LOAD: begin
								for (int i = 0; i < NUM_WEIGHTS; i++) begin
									w_q[i] <= init_q[i];
								end
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DOT: begin
					if (issue) begin
						for (int i = 0; i < NUM_WEIGHTS - 1; i++) begin
							w_q[i] <= w_q[i+1];
						end
						w_q[NUM_WEIGHTS-1] <= w_q[0];
					end
					if (cnt_q != '0 && cmd_q == CMD_PREDICT && clip24(pv_full)) begin
						flag_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (!issue) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (clip24(sum_full) || clip24(err_full)) begin
						flag_q <= 1'b1;
					end
					state_q <= (cmd_q == CMD_PREDICT) ? S_FIN : S_RATE;
				end
				S_RATE: begin
					state_q <= S_COPY;
				end
				S_COPY: begin
					cnt_q   <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (cnt_q != '0) begin
						for (int i = 0; i < NUM_WEIGHTS - 1; i++) begin
							w_q[i] <= w_q[i+1];
						end
						w_q[NUM_WEIGHTS-1] <= sat24(nw_full);
						if (clip24(nw_full)) begin
							flag_q <= 1'b1;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (!issue) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0] <= x_0;
			x_q[1] <= x_1;
			x_q[2] <= x_2;
			tgt_q  <= target;
			acc_q  <= '0;
			sum_q  <= '0;
			err_q  <= '0;
		end
		if ((state_q == S_DOT || state_q == S_STEP) && issue) begin
			for (int i = 0; i < NUM_WEIGHTS - 1; i++) begin
				x_q[i] <= x_q[i+1];
			end
			x_q[NUM_WEIGHTS-1] <= x_q[0];
		end
		if (state_q == S_DOT && cnt_q != '0) begin
			acc_q <= acc_q + prod[ACC_W-1:0];
			for (int i = 0; i < NUM_WEIGHTS - 1; i++) begin
				pv_q[i] <= pv_q[i+1];
			end
			pv_q[NUM_WEIGHTS-1] <= sat24(pv_full);
		end
		if (state_q == S_ERR) begin
			sum_q <= sat24(sum_full);
			err_q <= sat24(err_full);
		end
		if (state_q == S_COPY) begin
			re_q <= prod[MUL_A_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				value_q[i] <= (cmd_q == CMD_PREDICT) ? pv_q[i] : w_q[i];
			end
			sum_out_q <= sum_q;
			err_out_q <= err_q;
			sat_out_q <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_0   = value_q[0];
	assign value_1   = value_q[1];
	assign value_2   = value_q[2];
	assign sum_out   = sum_out_q;
	assign error_out = err_out_q;
	assign saturated = sat_out_q;

endmodule
`default_nettype wire

// ===== sim/tb_lms_three_weight_trainer_top.sv =====
// ----------------------------------------------------------------------------
// tb_lms_three_weight_trainer_top: self-checking bench for the LMS trainer
// A directed table first covers reset state, clipped products and weights,
// load, the dropped command and rate masking. Randomized phases follow. Each
// phase has its own rate and start weights and mostly trains toward a hidden
// linear teacher. A bit-accurate delta-rule model predicts every result beat not typed in the table.
// ----------------------------------------------------------------------------
module tb_lms_three_weight_trainer_top;
	import lmstr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_ROWS = 20;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 75;
	localparam longint Q_MAX = 64'sd8388607;
	localparam longint Q_MIN = -64'sd8388608;

	typedef struct packed {
		cmd_t           cmd;
		logic [X_W-1:0] x0;
		logic [X_W-1:0] x1;
		logic [X_W-1:0] x2;
		logic [X_W-1:0] tgt;
	} stim_t;

	typedef struct packed {
		logic [W_W-1:0] v0;
		logic [W_W-1:0] v1;
		logic [W_W-1:0] v2;
		logic [W_W-1:0] total;
		logic [W_W-1:0] err;
		logic           sat;
	} beat_t;

	typedef struct packed {
		logic           is_cfg;
		reg_idx_t       idx;
		logic [W_W-1:0] data;
		stim_t          s;
		logic           typed;
		beat_t          want;
	} row_t;

	localparam beat_t ZERO_BEAT = '0;
	localparam stim_t IDLE_STIM = '{CMD_NONE, 16'h0, 16'h0, 16'h0, 16'h0};
	localparam beat_t RAIL_BEAT = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h0, 24'h0, 1'b0};

	localparam row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
		'{1'b0, REG_RATE, 24'h0, '{CMD_PREDICT, 16'h0001, 16'h0002, 16'h0003, 16'h1000},
			1'b1, '{24'h0, 24'h0, 24'h0, 24'h0, 24'h010000, 1'b0}},
		'{1'b0, REG_RATE, 24'h0, '{CMD_PREDICT, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000},
			1'b1, '{24'h0, 24'h0, 24'h0, 24'h0, 24'hF80000, 1'b0}},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b1, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_LOAD, 16'h1234, 16'h8000, 16'h7FFF, 16'h0001},
			1'b1, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h1000, 16'hF000, 16'h7FFF, 16'h7FFF},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_PREDICT, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000},
			1'b0, ZERO_BEAT},
		'{1'b1, REG_RATE, 24'h00FFFF, IDLE_STIM, 1'b0, ZERO_BEAT},
		'{1'b1, REG_INIT0, 24'h7FFFFF, IDLE_STIM, 1'b0, ZERO_BEAT},
		'{1'b1, REG_INIT1, 24'h800000, IDLE_STIM, 1'b0, ZERO_BEAT},
		'{1'b1, REG_INIT2, 24'h7FFFFF, IDLE_STIM, 1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b1, RAIL_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_PREDICT, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000},
			1'b1, '{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1}},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_PREDICT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
			1'b0, ZERO_BEAT},
		'{1'b1, REG_RATE, 24'hAB0000, IDLE_STIM, 1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_TRAIN, 16'h7FFF, 16'h8000, 16'h0001, 16'h3039},
			1'b0, ZERO_BEAT},
		'{1'b0, REG_RATE, 24'h0, '{CMD_LOAD, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0},
			1'b1, RAIL_BEAT}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_RATE;
	logic [W_W-1:0]       cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     command = CMD_TRAIN;
	logic [X_W-1:0]       x_0 = '0;
	logic [X_W-1:0]       x_1 = '0;
	logic [X_W-1:0]       x_2 = '0;
	logic [X_W-1:0]       target = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [W_W-1:0]       value_0;
	logic [W_W-1:0]       value_1;
	logic [W_W-1:0]       value_2;
	logic [W_W-1:0]       sum_out;
	logic [W_W-1:0]       error_out;
	logic                 saturated;

	// weight model and its register copies
	longint rate_q016 = 655;
	longint w_init [3] = '{0, 0, 0};
	longint w_model [3] = '{0, 0, 0};

	beat_t neuron_results [$];
	int    teach [3];
	bit    calm = 1'b0;
	int    stall_hold = 0;
	int    cycle_cnt = 0;
	int    fails = 0;
	int    n_beats = 0;
	int    n_clipped = 0;
	int    n_writes = 0;
	int    n_cmd [4] = '{0, 0, 0, 0};

	lms_three_weight_trainer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.x_0       (x_0),
		.x_1       (x_1),
		.x_2       (x_2),
		.target    (target),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_0   (value_0),
		.value_1   (value_1),
		.value_2   (value_2),
		.sum_out   (sum_out),
		.error_out (error_out),
		.saturated (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint round_q(input longint v, input int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip_q716(input longint v, inout bit flag);
		if (v > Q_MAX) begin
			flag = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			flag = 1'b1;
			return Q_MIN;
		end
		return v;
	endfunction

	// delta-rule step on the weight model; returns 0 when no beat follows
	function automatic bit neuron_step(input stim_t s, output beat_t r);
		longint x [3];
		longint nv [3];
		longint acc;
		longint sum_full;
		longint sum_c;
		longint err_c;
		bit     flag;
		r = '0;
		flag = 1'b0;
		acc = 0;
		if (s.cmd == CMD_NONE) begin
			return 1'b0;
		end
		x[0] = $signed(s.x0);
		x[1] = $signed(s.x1);
		x[2] = $signed(s.x2);
		if (s.cmd == CMD_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				w_model[i] = w_init[i];
				nv[i] = w_model[i];
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				acc += x[i] * w_model[i];
			end
			sum_full = round_q(acc, 12);
			sum_c = clip_q716(sum_full, flag);
			err_c = clip_q716(longint'($signed(s.tgt)) * 16 - sum_full, flag);
			for (int i = 0; i < 3; i++) begin
				if (s.cmd == CMD_TRAIN) begin
					w_model[i] = clip_q716(w_model[i] +
						round_q(rate_q016 * err_c * x[i], 28), flag);
					nv[i] = w_model[i];
				end else begin
					nv[i] = clip_q716(round_q(x[i] * w_model[i], 12), flag);
				end
			end
			r.total = 24'(sum_c);
			r.err = 24'(err_c);
			r.sat = flag;
		end
		r.v0 = 24'(nv[0]);
		r.v1 = 24'(nv[1]);
		r.v2 = 24'(nv[2]);
		return 1'b1;
	endfunction

	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [X_W-1:0] draw_feature();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom_range(0, 8192) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly train toward the phase teacher; load, predict and dropped beats mixed in
	function automatic stim_t draw_sample(input bit first);
		stim_t  s;
		int     r;
		longint lin;
		r = $urandom_range(0, 99);
		s.x0 = draw_feature();
		s.x1 = draw_feature();
		s.x2 = draw_feature();
		s.tgt = 16'($urandom);
		if (first || r < 10) begin
			s.cmd = CMD_LOAD;
		end else if (r < 18) begin
			s.cmd = CMD_NONE;
		end else if (r < 45) begin
			s.cmd = CMD_PREDICT;
		end else begin
			s.cmd = CMD_TRAIN;
			if (r < 85) begin
				lin = (longint'($signed(s.x0)) * teach[0] + longint'($signed(s.x1)) * teach[1] +
					longint'($signed(s.x2)) * teach[2]) >>> 12;
				if (lin > 32767) begin
					lin = 32767;
				end else if (lin < -32768) begin
					lin = -32768;
				end
				s.tgt = 16'(lin);
			end
		end
		return s;
	endfunction

	task automatic send_item(input stim_t s, input int gap, input bit typed, input beat_t want);
		beat_t r;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= s.cmd;
		x_0 <= s.x0;
		x_1 <= s.x1;
		x_2 <= s.x2;
		target <= s.tgt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_cmd[s.cmd]++;
		if (neuron_step(s, r)) begin
			neuron_results.push_back(typed ? want : r);
		end
	endtask

	// drop valid and hold until every result is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (neuron_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [W_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RATE: rate_q016 = d[RATE_W-1:0];
			REG_INIT0: w_init[0] = $signed(d);
			REG_INIT1: w_init[1] = $signed(d);
			REG_INIT2: w_init[2] = $signed(d);
		endcase
		n_writes++;
	endtask

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (calm || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_hold <= draw_idle();
		end
	end

	always @(posedge clk) begin : result_check
		beat_t got;
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{value_0, value_1, value_2, sum_out, error_out, saturated};
			n_beats++;
			n_clipped += got.sat;
			if (neuron_results.size() == 0) begin
				if (fails < 10) begin
					$display("result beat %0d arrived with nothing pending", n_beats);
				end
				fails++;
			end else begin
				want = neuron_results.pop_front();
				if (got.v0 !== want.v0 || got.v1 !== want.v1 || got.v2 !== want.v2 ||
					got.total !== want.total || got.err !== want.err ||
					got.sat !== want.sat) begin
					if (fails < 10) begin
						$display("beat %0d got  %h %h %h sum %h err %h sat %b", n_beats,
							got.v0, got.v1, got.v2, got.total, got.err, got.sat);
						$display("beat %0d want %h %h %h sum %h err %h sat %b", n_beats,
							want.v0, want.v1, want.v2, want.total, want.err, want.sat);
					end
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				neuron_results.size());
			$display("tb_lms_three_weight_trainer_top NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		logic [RATE_W-1:0] rv;
		logic [W_W-1:0]    iv;
		stim_t             s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED_ROWS[i].is_cfg) begin
				settle();
				cfg_write(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
			end else begin
				send_item(DIRECTED_ROWS[i].s, draw_idle(), DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			calm = (p == 2);
			case (p)
				0: rv = 16'hFFFF;
				1: rv = 16'h0000;
				2: rv = 16'd655;
				default: rv = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(1, 4000));
			endcase
			cfg_write(REG_RATE, {8'($urandom), rv});
			for (int i = 0; i < 3; i++) begin
				if (p == 0) begin
					iv = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
				end else if ($urandom_range(0, 3) == 0) begin
					iv = 24'($urandom);
				end else begin
					iv = 24'($urandom_range(0, 1 << 19) - (1 << 18));
				end
				cfg_write(reg_idx_t'(i + 1), iv);
				teach[i] = int'($urandom_range(0, 16383)) - 8192;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2) begin
					settle();
				end
				s = draw_sample(k == 0);
				send_item(s, calm ? 0 : draw_idle(), 1'b0, ZERO_BEAT);
			end
		end
		settle();

		$display("covered %0d train, %0d predict, %0d load, %0d dropped beats, %0d reg writes",
			n_cmd[CMD_TRAIN], n_cmd[CMD_PREDICT], n_cmd[CMD_LOAD], n_cmd[CMD_NONE], n_writes);
		$display("%0d result beats compared, %0d flagged as clipped, %0d mismatches",
			n_beats, n_clipped, fails);
		if (fails == 0 && neuron_results.size() == 0) begin
			$display("tb_lms_three_weight_trainer_top OK");
		end else begin
			$display("tb_lms_three_weight_trainer_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lmstr_pkg.sv
src/lmstr_mul.sv
src/lms_three_weight_trainer_top.sv
sim/tb_lms_three_weight_trainer_top.sv
